// ===== sv/blca_pkg.sv =====
// shared types, constants and command/status structs for the lca unit
package blca_pkg;

    localparam int NODES    = 1024;
    localparam int LEVELS   = 10;
    localparam int NODE_W   = 10;
    localparam int DEPTH_W  = 10;
    localparam int NA_W     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JT_DEPTH = NODES * LEVELS;
    localparam int JA_W     = (JT_DEPTH > 1) ? $clog2(JT_DEPTH) : 1;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [NA_W-1:0]    naddr_t;
    typedef logic [JA_W-1:0]    jaddr_t;
    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [LEVELS-1:0]  lift_t;

    localparam depth_t DEPTH_MAX = '1;

    localparam logic REQ_ATTACH = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic  req_type;
        node_t node_a;
        node_t node_b;
    } blca_req_t;

    typedef struct packed {
        node_t ancestor;
        logic  status;
    } blca_rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ATT_RD,
        ST_ATT_EV,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_EV,
        ST_LIFT,
        ST_LIFT_W,
        ST_CMP,
        ST_UP_A,
        ST_UP_B,
        ST_UP_C,
        ST_FIN,
        ST_OUT
    } blca_state_t;

    typedef enum logic [1:0] {NS_A, NS_B, NS_CLR} nsel_t;
    typedef enum logic [1:0] {JN_A, JN_B, JN_CUR, JN_ANEW} jnode_t;
    typedef enum logic [1:0] {JL_LVL, JL_LVL_M1, JL_ZERO} jlvl_t;
    typedef enum logic {JW_B, JW_RD} jwd_t;
    typedef enum logic [1:0] {FS_ZERO, FS_A, FS_RD} fsel_t;

    typedef struct packed {
        logic   load;
        nsel_t  nsel;
        logic   att_we;
        logic   att_wd;
        logic   dep_we;
        logic   cap_a;
        jnode_t jnode;
        jlvl_t  jlvl;
        logic   jwe;
        jwd_t   jwd;
        logic   att_init;
        logic   row_step;
        logic   q_setup;
        logic   lvl_dec;
        logic   lvl_top;
        logic   lift_step;
        logic   up_cap;
        logic   up_step;
        logic   clr_step;
        logic   finish;
        logic   fin_err;
        fsel_t  fin_sel;
    } blca_cmd_t;

    typedef struct packed {
        logic att_err;
        logic q_err;
        logic k_bit;
        logic lvl_zero;
        logic lvl_last;
        logic a_eq_b;
        logic clr_last;
    } blca_stat_t;

endpackage

// ===== sv/binary_lifting_lca_unit.sv =====
// top level of the binary-lifting lowest common ancestor unit
//
// a request transfer is taken at a rising edge with start high and busy low;
// req carries req_type (attach or query), node_a and node_b.
// exactly one response follows each request: done is high for one cycle and
// rsp holds ancestor and status in that cycle; the receiver cannot stall it.
// after reset the unit runs a clearing pass over the attached flags, one node
// per cycle, with busy high; depth and jump rows are not cleared.
// attach: a read state and an evaluate state check the parent and write
// level 0; each further jump level takes one read and one write on the
// single-port jump memory.
// query: both depths are read and checked, the deeper node is lifted level
// by level, one compare follows, then both nodes are lifted together level
// by level and a final parent read gives the ancestor; the query ends early
// when the nodes meet after the first lift or on an error.
// the single-port jump memory sets the per-level cost of both operations.
// one request is in flight at a time; busy drops in the cycle done is raised.
module binary_lifting_lca_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  blca_pkg::blca_req_t req,
    output logic                busy,
    output logic                done,
    output blca_pkg::blca_rsp_t rsp
);

    blca_pkg::blca_cmd_t  cmd;
    blca_pkg::blca_stat_t stat;

    blca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    blca_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

// ===== sv/blca_dp.sv =====
// datapath: node and jump memories, working registers and result register
module blca_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blca_pkg::blca_req_t  req,
    input  blca_pkg::blca_cmd_t  cmd,
    output blca_pkg::blca_stat_t stat,
    output logic                 done,
    output blca_pkg::blca_rsp_t  rsp
);

    logic                 att_mem [blca_pkg::NODES];
    blca_pkg::depth_t     dep_mem [blca_pkg::NODES];
    blca_pkg::node_t      jt_mem  [blca_pkg::JT_DEPTH];

    logic                 att_rd_reg;
    blca_pkg::depth_t     dep_rd_reg;
    blca_pkg::node_t      jt_rd_reg;

    blca_pkg::node_t      a_reg;
    blca_pkg::node_t      b_reg;
    blca_pkg::node_t      cur_reg;
    blca_pkg::depth_t     dep_a_reg;
    logic                 att_a_reg;
    blca_pkg::lift_t      k_reg;
    blca_pkg::lvl_t       lvl_reg;
    blca_pkg::lvl_t       lvl_next;
    blca_pkg::naddr_t     clr_reg;
    logic                 done_reg;
    blca_pkg::blca_rsp_t  rsp_reg;

    blca_pkg::naddr_t     naddr;
    blca_pkg::depth_t     new_depth;
    blca_pkg::node_t      jn;
    blca_pkg::lvl_t       jl;
    blca_pkg::jaddr_t     jaddr;
    blca_pkg::node_t      jwdata;
    blca_pkg::node_t      anew;
    blca_pkg::node_t      bnew;
    logic                 up_diff;
    logic                 swap;
    blca_pkg::depth_t     diff;
    logic                 a_in;
    logic                 b_in;
    blca_pkg::node_t      fin_val;

    assign a_in = int'(a_reg) < blca_pkg::NODES;
    assign b_in = int'(b_reg) < blca_pkg::NODES;

    // node memory address
    always_comb
    begin
        case (cmd.nsel)
            blca_pkg::NS_A:   naddr = blca_pkg::naddr_t'(a_reg);
            blca_pkg::NS_B:   naddr = blca_pkg::naddr_t'(b_reg);
            blca_pkg::NS_CLR: naddr = clr_reg;
            default:          naddr = clr_reg;
        endcase
    end

    assign new_depth = (a_reg == b_reg) ? '0 :
                       (dep_rd_reg == blca_pkg::DEPTH_MAX) ? blca_pkg::DEPTH_MAX :
                       blca_pkg::depth_t'(dep_rd_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.att_we)
        begin
            att_mem[naddr] <= cmd.att_wd;
        end
        att_rd_reg <= att_mem[naddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dep_we)
        begin
            dep_mem[naddr] <= new_depth;
        end
        dep_rd_reg <= dep_mem[naddr];
    end

    // step-together comparison of the two ancestors
    assign up_diff = cur_reg != jt_rd_reg;
    assign anew    = up_diff ? cur_reg : a_reg;
    assign bnew    = up_diff ? jt_rd_reg : b_reg;

    always_comb
    begin
        case (cmd.jnode)
            blca_pkg::JN_A:    jn = a_reg;
            blca_pkg::JN_B:    jn = b_reg;
            blca_pkg::JN_CUR:  jn = cur_reg;
            blca_pkg::JN_ANEW: jn = anew;
            default:           jn = a_reg;
        endcase
        case (cmd.jlvl)
            blca_pkg::JL_LVL:    jl = lvl_reg;
            blca_pkg::JL_LVL_M1: jl = blca_pkg::lvl_t'(lvl_reg - 1'b1);
            blca_pkg::JL_ZERO:   jl = '0;
            default:             jl = '0;
        endcase
    end

    assign jaddr  = blca_pkg::jaddr_t'(blca_pkg::jaddr_t'(jn) *
                    blca_pkg::jaddr_t'(blca_pkg::LEVELS) + blca_pkg::jaddr_t'(jl));
    assign jwdata = (cmd.jwd == blca_pkg::JW_B) ? b_reg : jt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.jwe)
        begin
            jt_mem[jaddr] <= jwdata;
        end
        jt_rd_reg <= jt_mem[jaddr];
    end

    assign swap = dep_a_reg < dep_rd_reg;
    assign diff = swap ? blca_pkg::depth_t'(dep_rd_reg - dep_a_reg)
                       : blca_pkg::depth_t'(dep_a_reg - dep_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= req.node_a;
            b_reg <= req.node_b;
        end
        if (cmd.cap_a)
        begin
            att_a_reg <= att_rd_reg;
            dep_a_reg <= dep_rd_reg;
        end
        if (cmd.q_setup)
        begin
            if (swap)
            begin
                a_reg <= b_reg;
                b_reg <= a_reg;
            end
            k_reg <= blca_pkg::lift_t'(diff);
        end
        if (cmd.att_init)
        begin
            cur_reg <= b_reg;
        end
        if (cmd.row_step || cmd.up_cap)
        begin
            cur_reg <= jt_rd_reg;
        end
        if (cmd.lift_step)
        begin
            a_reg <= jt_rd_reg;
        end
        if (cmd.up_step)
        begin
            a_reg <= anew;
            b_reg <= bnew;
        end
    end

    always_comb
    begin
        lvl_next = lvl_reg;
        if (cmd.att_init)
        begin
            lvl_next = blca_pkg::lvl_t'(blca_pkg::LEVELS > 1);
        end
        else if (cmd.row_step)
        begin
            lvl_next = blca_pkg::lvl_t'(lvl_reg + 1'b1);
        end
        else if (cmd.q_setup || cmd.lvl_top)
        begin
            lvl_next = blca_pkg::lvl_t'(blca_pkg::LEVELS - 1);
        end
        else if (cmd.lvl_dec)
        begin
            lvl_next = blca_pkg::lvl_t'(lvl_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg  <= '0;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            lvl_reg  <= lvl_next;
            done_reg <= cmd.finish;
            if (cmd.clr_step)
            begin
                clr_reg <= blca_pkg::naddr_t'(clr_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        case (cmd.fin_sel)
            blca_pkg::FS_ZERO: fin_val = '0;
            blca_pkg::FS_A:    fin_val = a_reg;
            blca_pkg::FS_RD:   fin_val = jt_rd_reg;
            default:           fin_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.ancestor <= cmd.fin_err ? '0 : fin_val;
            rsp_reg.status   <= cmd.fin_err;
        end
    end

    assign stat.att_err  = !a_in || ((a_reg != b_reg) && !(b_in && att_rd_reg));
    assign stat.q_err    = !a_in || !b_in || !att_a_reg || !att_rd_reg;
    assign stat.k_bit    = k_reg[lvl_reg];
    assign stat.lvl_zero = lvl_reg == '0;
    assign stat.lvl_last = lvl_reg == blca_pkg::lvl_t'(blca_pkg::LEVELS - 1);
    assign stat.a_eq_b   = a_reg == b_reg;
    assign stat.clr_last = clr_reg == blca_pkg::naddr_t'(blca_pkg::NODES - 1);

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= blca_pkg::lvl_t'(blca_pkg::LEVELS - 1))
        else $error("level counter out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status |-> rsp.ancestor == '0)
        else $error("error result carries an ancestor");

endmodule

// ===== sv/blca_ctrl.sv =====
// controller state machine sequencing attach, query and the clearing pass
module blca_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 req_type,
    input  blca_pkg::blca_stat_t stat,
    output logic                 busy,
    output blca_pkg::blca_cmd_t  cmd
);

    blca_pkg::blca_state_t state_reg;
    blca_pkg::blca_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blca_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            blca_pkg::ST_CLEAR:
            begin
                cmd.nsel     = blca_pkg::NS_CLR;
                cmd.att_we   = 1'b1;
                cmd.att_wd   = 1'b0;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = blca_pkg::ST_IDLE;
                end
            end
            blca_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_type == blca_pkg::REQ_QUERY) ? blca_pkg::ST_Q_RDA
                                                                    : blca_pkg::ST_ATT_RD;
                end
            end
            blca_pkg::ST_ATT_RD:
            begin
                cmd.nsel   = blca_pkg::NS_B;
                state_next = blca_pkg::ST_ATT_EV;
            end
            blca_pkg::ST_ATT_EV:
            begin
                if (stat.att_err)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_err = 1'b1;
                    cmd.fin_sel = blca_pkg::FS_ZERO;
                    state_next  = blca_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.nsel     = blca_pkg::NS_A;
                    cmd.att_we   = 1'b1;
                    cmd.att_wd   = 1'b1;
                    cmd.dep_we   = 1'b1;
                    cmd.jwe      = 1'b1;
                    cmd.jnode    = blca_pkg::JN_A;
                    cmd.jlvl     = blca_pkg::JL_ZERO;
                    cmd.jwd      = blca_pkg::JW_B;
                    cmd.att_init = 1'b1;
                    if (blca_pkg::LEVELS == 1)
                    begin
                        cmd.finish  = 1'b1;
                        cmd.fin_sel = blca_pkg::FS_ZERO;
                        state_next  = blca_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = blca_pkg::ST_ROW_RD;
                    end
                end
            end
            blca_pkg::ST_ROW_RD:
            begin
                cmd.jnode  = blca_pkg::JN_CUR;
                cmd.jlvl   = blca_pkg::JL_LVL_M1;
                state_next = blca_pkg::ST_ROW_WR;
            end
            blca_pkg::ST_ROW_WR:
            begin
                cmd.jwe   = 1'b1;
                cmd.jnode = blca_pkg::JN_A;
                cmd.jlvl  = blca_pkg::JL_LVL;
                cmd.jwd   = blca_pkg::JW_RD;
                if (stat.lvl_last)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_sel = blca_pkg::FS_ZERO;
                    state_next  = blca_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.row_step = 1'b1;
                    state_next   = blca_pkg::ST_ROW_RD;
                end
            end
            blca_pkg::ST_Q_RDA:
            begin
                cmd.nsel   = blca_pkg::NS_A;
                state_next = blca_pkg::ST_Q_RDB;
            end
            blca_pkg::ST_Q_RDB:
            begin
                cmd.nsel   = blca_pkg::NS_B;
                cmd.cap_a  = 1'b1;
                state_next = blca_pkg::ST_Q_EV;
            end
            blca_pkg::ST_Q_EV:
            begin
                if (stat.q_err)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_err = 1'b1;
                    cmd.fin_sel = blca_pkg::FS_ZERO;
                    state_next  = blca_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.q_setup = 1'b1;
                    state_next  = blca_pkg::ST_LIFT;
                end
            end
            blca_pkg::ST_LIFT:
            begin
                if (stat.k_bit)
                begin
                    cmd.jnode  = blca_pkg::JN_A;
                    cmd.jlvl   = blca_pkg::JL_LVL;
                    state_next = blca_pkg::ST_LIFT_W;
                end
                else if (stat.lvl_zero)
                begin
                    state_next = blca_pkg::ST_CMP;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                end
            end
            blca_pkg::ST_LIFT_W:
            begin
                cmd.lift_step = 1'b1;
                if (stat.lvl_zero)
                begin
                    state_next = blca_pkg::ST_CMP;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                    state_next  = blca_pkg::ST_LIFT;
                end
            end
            blca_pkg::ST_CMP:
            begin
                if (stat.a_eq_b)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_sel = blca_pkg::FS_A;
                    state_next  = blca_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.lvl_top = 1'b1;
                    state_next  = blca_pkg::ST_UP_A;
                end
            end
            blca_pkg::ST_UP_A:
            begin
                cmd.jnode  = blca_pkg::JN_A;
                cmd.jlvl   = blca_pkg::JL_LVL;
                state_next = blca_pkg::ST_UP_B;
            end
            blca_pkg::ST_UP_B:
            begin
                cmd.jnode  = blca_pkg::JN_B;
                cmd.jlvl   = blca_pkg::JL_LVL;
                cmd.up_cap = 1'b1;
                state_next = blca_pkg::ST_UP_C;
            end
            blca_pkg::ST_UP_C:
            begin
                cmd.up_step = 1'b1;
                if (stat.lvl_zero)
                begin
                    state_next = blca_pkg::ST_FIN;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                    cmd.jnode   = blca_pkg::JN_ANEW;
                    cmd.jlvl    = blca_pkg::JL_LVL_M1;
                    state_next  = blca_pkg::ST_UP_B;
                end
            end
            blca_pkg::ST_FIN:
            begin
                cmd.jnode  = blca_pkg::JN_A;
                cmd.jlvl   = blca_pkg::JL_ZERO;
                state_next = blca_pkg::ST_OUT;
            end
            blca_pkg::ST_OUT:
            begin
                cmd.finish  = 1'b1;
                cmd.fin_sel = blca_pkg::FS_RD;
                state_next  = blca_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = blca_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != blca_pkg::ST_IDLE;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == blca_pkg::ST_IDLE |-> !cmd.jwe && !cmd.att_we && !cmd.dep_we)
        else $error("memory write while idle");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == blca_pkg::ST_IDLE)
        else $error("finish not followed by idle");

endmodule
